>>> rtl/core/work_break_phase_timer_unit_defines.svh
// ----------------------------------------------------------------------------
// Work/break phase timer - assertion macros
// Shared property wrappers for the checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef WORK_BREAK_PHASE_TIMER_UNIT_DEFINES_SVH
`define WORK_BREAK_PHASE_TIMER_UNIT_DEFINES_SVH

// plain clocked property
`define WBPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a result that waits for the sink must not change
`define WBPT_ASSERT_HOLD(lbl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && !out_ready) |=> (out_valid && $stable(sig))) else $error(msg);

`endif

>>> rtl/core/wbpt_pkg.sv
// ----------------------------------------------------------------------------
// Work/break phase timer - package
// Field widths, action and phase codes, item and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package wbpt_pkg;

    localparam int ACTION_W  = 3;
    localparam int COUNT8_W  = 8;
    localparam int PHASE_W   = 3;
    localparam int SECS_W    = 14;
    localparam int SESSION_W = 9;
    localparam int CFG_IDX_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESUME = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SKIP   = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_STATUS = 3'd6;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WORK   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BREAK  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LONG   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAUSED = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 2'd2;

    localparam logic [COUNT8_W-1:0] WORK_MIN_RST  = 8'd25;
    localparam logic [COUNT8_W-1:0] BREAK_MIN_RST = 8'd5;
    localparam logic [COUNT8_W-1:0] LONG_MIN_RST  = 8'd15;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COUNT8_W-1:0] session_total;
        logic [COUNT8_W-1:0] sessions_done;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic [SECS_W-1:0]    remaining_seconds;
        logic [SESSION_W-1:0] session_number;
        logic [COUNT8_W-1:0]  planned_total;
        logic                 session_ended;
        logic                 all_finished;
    } result_t;

    // minutes * 60 as (m << 6) - (m << 2)
    function automatic logic [SECS_W-1:0] minutes_to_secs(input logic [COUNT8_W-1:0] mins);
        logic [SECS_W-1:0] m;
        begin
            m = SECS_W'(mins);
            return (m << 6) - (m << 2);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/work_break_phase_timer_unit.sv
// An accepted item waits in the input register; its result is computed combinationally and
// loaded into the result register. Throughput: one item per cycle while the sink is ready;
// the phase update is one register-to-register step.
// While a result waits for the sink, one more input transfer can land in the input register,
// then in_ready stays low until the result transfers.
// Reset (rst_n low, asynchronous): idle, no session, phase lengths 25/5/15 minutes.
// ----------------------------------------------------------------------------
// Work/break phase timer - top level
// Counts down work, short break and long break phases on tick transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module work_break_phase_timer_unit
    import wbpt_pkg::*;
#(
    parameter int SESSIONS_PER_CYCLE = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [COUNT8_W-1:0]  cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ACTION_W-1:0]  action,
    input  wire logic [COUNT8_W-1:0]  session_total,
    input  wire logic [COUNT8_W-1:0]  sessions_done,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [PHASE_W-1:0]        phase,
    output logic [SECS_W-1:0]         remaining_seconds,
    output logic [SESSION_W-1:0]      session_number,
    output logic [COUNT8_W-1:0]       planned_total,
    output logic                      session_ended,
    output logic                      all_finished
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    fire;
    result_t result_next;
    result_t result;

    assign in_item.action        = action;
    assign in_item.session_total = session_total;
    assign in_item.sessions_done = sessions_done;

    assign fire = item_valid && out_free;

    wbpt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    wbpt_core #(
        .SESSIONS_PER_CYCLE (SESSIONS_PER_CYCLE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result_next)
    );

    wbpt_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result_in  (result_next),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result)
    );

    assign phase             = result.phase;
    assign remaining_seconds = result.remaining_seconds;
    assign session_number    = result.session_number;
    assign planned_total     = result.planned_total;
    assign session_ended     = result.session_ended;
    assign all_finished      = result.all_finished;

endmodule

`default_nettype wire

>>> rtl/core/wbpt_in_reg.sv
// ----------------------------------------------------------------------------
// Work/break phase timer - input register
// Holds one accepted item until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpt_in_reg
    import wbpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/core/wbpt_core.sv
// ----------------------------------------------------------------------------
// Work/break phase timer - phase state and update logic
// Holds timer state and phase lengths, computes the state after one item.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpt_core
    import wbpt_pkg::*;
#(
    parameter int SESSIONS_PER_CYCLE = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [COUNT8_W-1:0]  cfg_wdata,
    input  wire logic                 fire,
    input  wire item_t                item,
    output result_t                   result
);

    localparam int RES_W     = $clog2(SESSIONS_PER_CYCLE);
    localparam int RES_SHIFT = 13;
    localparam int RES_MULT  = (2 ** RES_SHIFT + SESSIONS_PER_CYCLE - 1) / SESSIONS_PER_CYCLE;
    localparam int PROD_W    = SESSION_W + RES_SHIFT;
    localparam logic [RES_W-1:0] RES_LAST = RES_W'(SESSIONS_PER_CYCLE - 1);
    localparam logic [RES_W-1:0] RES_ONE  = RES_W'(1);

    logic [COUNT8_W-1:0]  work_min_reg;
    logic [COUNT8_W-1:0]  break_min_reg;
    logic [COUNT8_W-1:0]  long_min_reg;

    logic [PHASE_W-1:0]   phase_reg,       phase_next;
    logic [1:0]           paused_from_reg, paused_from_next;
    logic [SECS_W-1:0]    countdown_reg,   countdown_next;
    logic [SESSION_W-1:0] session_reg,     session_next;
    logic [COUNT8_W-1:0]  total_reg,       total_next;
    // session count modulo sessions per cycle
    logic [RES_W-1:0]     residue_reg,     residue_next;

    logic                 ended;
    logic                 all_done;

    logic [SESSION_W-1:0] sc_inc;
    logic [RES_W-1:0]     res_inc;
    logic                 sessions_over;
    logic                 long_due;
    logic [PHASE_W-1:0]   end_from;
    logic                 running;

    logic [SESSION_W-1:0] start_count;
    logic [PROD_W-1:0]    start_prod;
    logic [SESSION_W-1:0] start_quot;
    logic [SESSION_W-1:0] start_rem;

    // configuration, to be written by the user only while no item is in flight; not enforced by the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_min_reg  <= WORK_MIN_RST;
            break_min_reg <= BREAK_MIN_RST;
            long_min_reg  <= LONG_MIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_WORK_MIN:  work_min_reg  <= cfg_wdata;
                CFG_BREAK_MIN: break_min_reg <= cfg_wdata;
                CFG_LONG_MIN:  long_min_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // start count mod N by reciprocal multiply, exact for 9-bit counts
    assign start_count = SESSION_W'(item.sessions_done) + SESSION_W'(1);
    assign start_prod  = PROD_W'(start_count) * PROD_W'(RES_MULT);
    assign start_quot  = start_prod[PROD_W-1:RES_SHIFT];
    assign start_rem   = start_count - SESSION_W'(start_quot * SESSION_W'(SESSIONS_PER_CYCLE));

    assign sc_inc        = session_reg + SESSION_W'(1);
    assign res_inc       = (residue_reg == RES_LAST) ? '0 : residue_reg + RES_ONE;
    assign sessions_over = sc_inc > SESSION_W'(total_reg);
    assign long_due      = (res_inc == RES_ONE) && (sc_inc > SESSION_W'(1));
    assign running       = phase_reg inside {PH_WORK, PH_BREAK, PH_LONG};
    assign end_from      = (phase_reg == PH_PAUSED) ? {1'b0, paused_from_reg} : phase_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        paused_from_next = paused_from_reg;
        countdown_next   = countdown_reg;
        session_next     = session_reg;
        total_next       = total_reg;
        residue_next     = residue_reg;
        ended            = 1'b0;
        all_done         = 1'b0;

        case (item.action)
            ACT_TICK, ACT_SKIP:
            begin
                if ((item.action == ACT_TICK && running && countdown_reg > SECS_W'(1)))
                begin
                    countdown_next = countdown_reg - SECS_W'(1);
                end
                else if ((item.action == ACT_TICK && running) ||
                         (item.action == ACT_SKIP && phase_reg != PH_IDLE))
                begin
                    // phase ran out or was skipped
                    countdown_next = '0;
                    if (end_from == PH_WORK)
                    begin
                        session_next = sc_inc;
                        residue_next = res_inc;
                        ended        = 1'b1;
                        if (sessions_over)
                        begin
                            phase_next = PH_IDLE;
                            all_done   = 1'b1;
                        end
                        else if (long_due)
                        begin
                            phase_next     = PH_LONG;
                            countdown_next = minutes_to_secs(long_min_reg);
                        end
                        else
                        begin
                            phase_next     = PH_BREAK;
                            countdown_next = minutes_to_secs(break_min_reg);
                        end
                    end
                    else
                    begin
                        phase_next     = PH_WORK;
                        countdown_next = minutes_to_secs(work_min_reg);
                    end
                end
            end
            ACT_START:
            begin
                phase_next       = PH_WORK;
                paused_from_next = PH_WORK[1:0];
                countdown_next   = minutes_to_secs(work_min_reg);
                session_next     = start_count;
                total_next       = item.session_total;
                residue_next     = start_rem[RES_W-1:0];
            end
            ACT_PAUSE:
            begin
                if (running)
                begin
                    paused_from_next = phase_reg[1:0];
                    phase_next       = PH_PAUSED;
                end
            end
            ACT_RESUME:
            begin
                if (phase_reg == PH_PAUSED)
                begin
                    phase_next = {1'b0, paused_from_reg};
                end
            end
            ACT_RESET:
            begin
                phase_next       = PH_IDLE;
                paused_from_next = PH_WORK[1:0];
                countdown_next   = '0;
                session_next     = '0;
                total_next       = '0;
                residue_next     = '0;
            end
            default:
            begin
                // status query and unused code: no change
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            paused_from_reg <= PH_WORK[1:0];
            countdown_reg   <= '0;
            session_reg     <= '0;
            total_reg       <= '0;
            residue_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            paused_from_reg <= paused_from_next;
            countdown_reg   <= countdown_next;
            session_reg     <= session_next;
            total_reg       <= total_next;
            residue_reg     <= residue_next;
        end
    end

    assign result.phase             = phase_next;
    assign result.remaining_seconds = countdown_next;
    assign result.session_number    = session_next;
    assign result.planned_total     = total_next;
    assign result.session_ended     = ended;
    assign result.all_finished      = all_done;

endmodule

`default_nettype wire

>>> rtl/core/wbpt_out_reg.sv
// ----------------------------------------------------------------------------
// Work/break phase timer - result register
// Holds one status result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpt_out_reg
    import wbpt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result_in,
    output logic         free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // register can take a new result when empty or when drained this cycle
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/wbpt_checker.sv
// ----------------------------------------------------------------------------
// Work/break phase timer - port checker
// Watches the top-level ports for status results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

`include "work_break_phase_timer_unit_defines.svh"

module wbpt_checker
    import wbpt_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [PHASE_W-1:0]   phase,
    input wire logic [SECS_W-1:0]    remaining_seconds,
    input wire logic [SESSION_W-1:0] session_number,
    input wire logic [COUNT8_W-1:0]  planned_total,
    input wire logic                 session_ended,
    input wire logic                 all_finished
);

    // completion always ends a work session and leaves the block idle
    `WBPT_ASSERT(a_all_done_idle,
        (out_valid && all_finished) |-> (session_ended && phase == PH_IDLE),
        "all_finished without idle end of session")

    // a work session that ends without completion starts a break
    `WBPT_ASSERT(a_end_to_break,
        (out_valid && session_ended && !all_finished) |-> (phase == PH_BREAK || phase == PH_LONG),
        "session end did not start a break")

    // idle never carries a running countdown
    `WBPT_ASSERT(a_idle_zero,
        (out_valid && phase == PH_IDLE) |-> (remaining_seconds == '0),
        "idle with nonzero countdown")

    // a stalled result keeps its status
    `WBPT_ASSERT_HOLD(a_out_hold,
        {phase, remaining_seconds, session_number, planned_total, session_ended, all_finished},
        "result changed while stalled")

endmodule

bind work_break_phase_timer_unit wbpt_checker u_wbpt_checker (.*);

`default_nettype wire

>>> sim/work_break_phase_timer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work/break phase timer - testbench
// Sends tick and control actions through the input channel and checks every
// status against a cycle-free predictor of the phase timer, over several
// phase-length settings and with random idling on both channels.
// ----------------------------------------------------------------------------

module work_break_phase_timer_unit_tb;
    import wbpt_pkg::*;

    localparam int SESSIONS_PER_CYCLE = 4;
    localparam int SECS_PER_MIN       = 60;
    localparam int HALF_PERIOD        = 6;
    localparam int LIMIT_CYCLES       = 200000;
    localparam int DRAIN_CYCLES       = 2000;
    localparam int MIX_ITEMS          = 130;
    localparam int PRINT_CAP          = 40;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [COUNT8_W-1:0]  cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ACTION_W-1:0]  action = '0;
    logic [COUNT8_W-1:0]  session_total = '0;
    logic [COUNT8_W-1:0]  sessions_done = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PHASE_W-1:0]   phase;
    logic [SECS_W-1:0]    remaining_seconds;
    logic [SESSION_W-1:0] session_number;
    logic [COUNT8_W-1:0]  planned_total;
    logic                 session_ended;
    logic                 all_finished;

    work_break_phase_timer_unit #(
        .SESSIONS_PER_CYCLE (SESSIONS_PER_CYCLE)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .session_total     (session_total),
        .sessions_done     (sessions_done),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .phase             (phase),
        .remaining_seconds (remaining_seconds),
        .session_number    (session_number),
        .planned_total     (planned_total),
        .session_ended     (session_ended),
        .all_finished      (all_finished)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    item_t   pending_items_q[$];
    result_t expected_status_q[$];
    logic    in_taken = 1'b0;
    int      send_idle_pct = 27;
    int      recv_idle_pct = 57;
    int      mismatch_count = 0;
    int      status_seen = 0;

    // shadow of the phase-length registers
    logic [COUNT8_W-1:0] work_len  = WORK_MIN_RST;
    logic [COUNT8_W-1:0] break_len = BREAK_MIN_RST;
    logic [COUNT8_W-1:0] long_len  = LONG_MIN_RST;

    // predicted timer state
    logic [PHASE_W-1:0]   run_phase  = PH_IDLE;
    logic [PHASE_W-1:0]   held_phase = PH_WORK;
    logic [SECS_W-1:0]    secs_left  = '0;
    logic [SESSION_W-1:0] session_no = '0;
    logic [COUNT8_W-1:0]  plan_total = '0;
    logic                 ended_now;
    logic                 all_now;

    function automatic logic [SECS_W-1:0] to_secs(input logic [COUNT8_W-1:0] mins);
        return SECS_W'(int'(mins) * SECS_PER_MIN);
    endfunction

    function automatic void clear_timer();
        run_phase  = PH_IDLE;
        held_phase = PH_WORK;
        secs_left  = '0;
        session_no = '0;
        plan_total = '0;
    endfunction

    // the phase 'from' has run out: move on to the one that follows
    function automatic void close_phase(input logic [PHASE_W-1:0] from);
        logic go_long;
        if (from == PH_WORK)
        begin
            session_no = session_no + 9'd1;
            ended_now  = 1'b1;
            if (session_no > {1'b0, plan_total})
            begin
                run_phase = PH_IDLE;
                all_now   = 1'b1;
            end
            else
            begin
                go_long   = (session_no % SESSIONS_PER_CYCLE == 1) && (session_no > 1);
                run_phase = go_long ? PH_LONG : PH_BREAK;
                secs_left = to_secs(go_long ? long_len : break_len);
            end
        end
        else
        begin
            run_phase = PH_WORK;
            secs_left = to_secs(work_len);
        end
    endfunction

    function automatic result_t predict_status(input item_t it);
        result_t r;
        ended_now = 1'b0;
        all_now   = 1'b0;
        case (it.action)
            ACT_TICK:
                if (run_phase != PH_IDLE && run_phase != PH_PAUSED)
                begin
                    if (secs_left > 1)
                        secs_left = secs_left - 1'b1;
                    else
                    begin
                        secs_left = '0;
                        close_phase(run_phase);
                    end
                end
            ACT_START:
            begin
                clear_timer();
                plan_total = it.session_total;
                session_no = {1'b0, it.sessions_done} + 9'd1;
                run_phase  = PH_WORK;
                secs_left  = to_secs(work_len);
            end
            ACT_PAUSE:
                if (run_phase != PH_IDLE && run_phase != PH_PAUSED)
                begin
                    held_phase = run_phase;
                    run_phase  = PH_PAUSED;
                end
            ACT_RESUME:
                if (run_phase == PH_PAUSED)
                    run_phase = held_phase;
            ACT_RESET:
                clear_timer();
            ACT_SKIP:
                if (run_phase != PH_IDLE)
                begin
                    secs_left = '0;
                    close_phase(run_phase == PH_PAUSED ? held_phase : run_phase);
                end
            default:
                ;
        endcase
        r.phase             = run_phase;
        r.remaining_seconds = secs_left;
        r.session_number    = session_no;
        r.planned_total     = plan_total;
        r.session_ended     = ended_now;
        r.all_finished      = all_now;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] status %0d %s: got %0d, expected %0d",
                     $realtime, status_seen, what, got, want);
    endtask

    // input side: a new item only once the previous one has transferred
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_items_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                {action, session_total, sessions_done} = pending_items_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_status_q.push_back(
                    predict_status({action, session_total, sessions_done}));
            if (out_valid && out_ready)
            begin
                if (expected_status_q.size() == 0)
                    report_mismatch("status with nothing outstanding", phase, 0);
                else
                begin
                    want = expected_status_q.pop_front();
                    if (phase !== want.phase)
                        report_mismatch("phase", phase, want.phase);
                    if (remaining_seconds !== want.remaining_seconds)
                        report_mismatch("remaining_seconds", remaining_seconds,
                                        want.remaining_seconds);
                    if (session_number !== want.session_number)
                        report_mismatch("session_number", session_number,
                                        want.session_number);
                    if (planned_total !== want.planned_total)
                        report_mismatch("planned_total", planned_total, want.planned_total);
                    if (session_ended !== want.session_ended)
                        report_mismatch("session_ended", session_ended, want.session_ended);
                    if (all_finished !== want.all_finished)
                        report_mismatch("all_finished", all_finished, want.all_finished);
                end
                status_seen++;
            end
        end
    end

    task automatic push_item(input logic [ACTION_W-1:0] act,
                             input logic [COUNT8_W-1:0] tot,
                             input logic [COUNT8_W-1:0] done);
        item_t it;
        it.action        = act;
        it.session_total = tot;
        it.sessions_done = done;
        pending_items_q.push_back(it);
    endtask

    task automatic program_lengths(input logic [COUNT8_W-1:0] w,
                                   input logic [COUNT8_W-1:0] b,
                                   input logic [COUNT8_W-1:0] l);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_WORK_MIN;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_addr  <= CFG_BREAK_MIN;
        cfg_wdata <= b;
        @(negedge clk);
        cfg_addr  <= CFG_LONG_MIN;
        cfg_wdata <= l;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        work_len  = w;
        break_len = b;
        long_len  = l;
    endtask

    task automatic wait_drained();
        for (int k = 0; k < DRAIN_CYCLES &&
             (pending_items_q.size() > 0 || in_valid || expected_status_q.size() > 0); k++)
        begin
            // let the driver's update at this edge settle before looking
            @(negedge clk);
            #1;
        end
    endtask

    function automatic logic [ACTION_W-1:0] pick_session_action();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 58)
            return ACT_TICK;
        else if (r < 72)
            return ACT_SKIP;
        else if (r < 81)
            return ACT_PAUSE;
        else if (r < 90)
            return ACT_RESUME;
        else if (r < 95)
            return ACT_STATUS;
        else if (r < 97)
            return ACT_RESET;
        return ACT_UNUSED;
    endfunction

    // mostly started sessions driven by ticks and controls, some raw noise
    task automatic queue_session_mix(input int budget);
        int n;
        int len;
        n = 0;
        while (n < budget)
        begin
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(4, 1);
                repeat (len)
                    push_item(ACTION_W'($urandom_range(7)), COUNT8_W'($urandom_range(255)),
                              COUNT8_W'($urandom_range(255)));
            end
            else
            begin
                if ($urandom_range(5) == 0)
                    push_item(ACT_START, COUNT8_W'($urandom_range(255)),
                              COUNT8_W'($urandom_range(255)));
                else
                    push_item(ACT_START, COUNT8_W'($urandom_range(6)),
                              COUNT8_W'($urandom_range(8)));
                len = $urandom_range(60, 10);
                repeat (len - 1)
                    push_item(pick_session_action(), COUNT8_W'($urandom_range(255)),
                              COUNT8_W'($urandom_range(255)));
            end
            n += len;
        end
    endtask

    int work_set  [6] = '{0, 1, 0, 255, 1, 2};
    int break_set [6] = '{0, 0, 1, 255, 2, 0};
    int long_set  [6] = '{0, 1, 2, 255, 0, 1};

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset lengths, idle handling, start/pause/resume/skip corners
        push_item(ACT_STATUS, 8'd0, 8'd0);
        push_item(ACT_TICK, 8'd0, 8'd0);
        push_item(ACT_PAUSE, 8'd0, 8'd0);
        push_item(ACT_RESUME, 8'd0, 8'd0);
        push_item(ACT_SKIP, 8'd0, 8'd0);
        push_item(ACT_UNUSED, 8'd255, 8'd255);
        push_item(ACT_START, 8'd0, 8'd255);     // counter runs up to 257
        push_item(ACT_SKIP, 8'd0, 8'd0);
        push_item(ACT_START, 8'd255, 8'd0);
        push_item(ACT_TICK, 8'd0, 8'd0);
        push_item(ACT_PAUSE, 8'd0, 8'd0);
        push_item(ACT_TICK, 8'd0, 8'd0);
        push_item(ACT_PAUSE, 8'd0, 8'd0);
        push_item(ACT_RESUME, 8'd0, 8'd0);
        push_item(ACT_SKIP, 8'd0, 8'd0);
        push_item(ACT_PAUSE, 8'd0, 8'd0);
        push_item(ACT_SKIP, 8'd0, 8'd0);        // skip the saved break while paused
        push_item(ACT_RESET, 8'd0, 8'd0);
        push_item(ACT_START, 8'd8, 8'd3);
        push_item(ACT_SKIP, 8'd0, 8'd0);        // fourth session ends into a long break
        push_item(ACT_RESUME, 8'd0, 8'd0);
        push_item(ACT_STATUS, 8'd0, 8'd0);
        push_item(ACT_TICK, 8'd0, 8'd0);

        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            program_lengths(COUNT8_W'(work_set[p]), COUNT8_W'(break_set[p]),
                            COUNT8_W'(long_set[p]));
            @(posedge clk);
            if (p < 2)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 57;
            end
            else if (p < 4)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_session_mix(MIX_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_status_q.size() != 0)
            report_mismatch("statuses never delivered", 0, expected_status_q.size());
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> work_break_phase_timer_unit.f
+incdir+rtl/core
rtl/core/wbpt_pkg.sv
rtl/core/wbpt_in_reg.sv
rtl/core/wbpt_core.sv
rtl/core/wbpt_out_reg.sv
rtl/core/work_break_phase_timer_unit.sv
rtl/core/wbpt_checker.sv
sim/work_break_phase_timer_unit_tb.sv
